/* hdl/ctrm_pkg.sv */
// ctrm_pkg: shared constants and payload/memory-command types for the
// Cartesian-tree range-maximum engine. No dependencies.
`timescale 1ns / 1ps

package ctrm_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int NODE_W      = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int VALUE_W     = 30;
    localparam int POS_W       = 11;
    localparam int CMP_W       = (NODE_W > POS_W) ? NODE_W : POS_W;

    localparam logic [NODE_W-1:0] MAX_NODE = NODE_W'(MAX_ENTRIES);

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   left_position;
        logic [POS_W-1:0]   right_position;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0] max_value;
        logic               error;
    } t_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0]  rd_addr;
        logic               val_we;
        logic [ADDR_W-1:0]  val_wa;
        logic [VALUE_W-1:0] val_wd;
        logic               lc_we;
        logic [ADDR_W-1:0]  lc_wa;
        logic [NODE_W-1:0]  lc_wd;
        logic               rc_we;
        logic [ADDR_W-1:0]  rc_wa;
        logic [NODE_W-1:0]  rc_wd;
        logic               pl_we;
        logic [ADDR_W-1:0]  pl_wa;
        logic [NODE_W-1:0]  pl_wd;
    } t_mem_cmd;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [NODE_W-1:0]  lc;
        logic [NODE_W-1:0]  rc;
        logic [NODE_W-1:0]  pl;
    } t_mem_rd;

endpackage

/* hdl/ctrm_ram.sv */
// ctrm_ram: generic simple dual-port RAM, one write port, one registered read.
// No dependencies.
`timescale 1ns / 1ps

module ctrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wa,
    input  logic [WIDTH-1:0]         i_wd,
    input  logic [$clog2(DEPTH)-1:0] i_ra,
    output logic [WIDTH-1:0]         o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_rd <= r_mem[i_ra];
    end

    assign o_rd = r_rd;

endmodule

/* hdl/ctrm_ctrl.sv */
// ctrm_ctrl: sequencer for append climbs and query descents, with the shared
// compare unit and the result register. Depends on ctrm_pkg.
`timescale 1ns / 1ps

module ctrm_ctrl
    import ctrm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_req     i_req,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    output t_rsp     o_rsp,
    output t_mem_cmd o_mem,
    input  t_mem_rd  i_rd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AINIT,
        S_AWAIT,
        S_ACMP,
        S_AFIX,
        S_QWAIT,
        S_QCMP,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [VALUE_W-1:0] r_val;
    logic [POS_W-1:0]   r_lo;
    logic [POS_W-1:0]   r_hi;
    logic [NODE_W-1:0]  r_node;
    logic [NODE_W-1:0]  r_cur;
    logic [NODE_W-1:0]  r_moved;
    logic [NODE_W-1:0]  r_root;
    logic [NODE_W-1:0]  r_last;
    logic [NODE_W-1:0]  r_count;
    t_rsp               r_res;
    t_rsp               r_out;
    logic               r_out_valid;

    logic [POS_W-1:0]   req_lo;
    logic [POS_W-1:0]   req_hi;
    logic               req_bad;
    logic               cmp_lt;
    logic               cur_below;
    logic               cur_in;
    logic [NODE_W-1:0]  desc_next;
    logic               load_out;

    function automatic logic [ADDR_W-1:0] node_addr(input logic [NODE_W-1:0] n);
        logic [NODE_W-1:0] t;
        t = n - NODE_W'(1);
        return t[ADDR_W-1:0];
    endfunction

    assign req_lo  = (i_req.left_position < i_req.right_position) ?
                     i_req.left_position : i_req.right_position;
    assign req_hi  = (i_req.left_position < i_req.right_position) ?
                     i_req.right_position : i_req.left_position;
    assign req_bad = (req_lo == '0) || (CMP_W'(req_hi) > CMP_W'(r_count));

    // shared compare unit
    assign cmp_lt    = i_rd.value < r_val;
    assign cur_below = CMP_W'(r_cur) < CMP_W'(r_lo);
    assign cur_in    = !cur_below && (CMP_W'(r_cur) <= CMP_W'(r_hi));
    assign desc_next = cur_below ? i_rd.rc : i_rd.lc;

    assign load_out  = (r_state == S_EMIT) && (!r_out_valid || i_rsp_ready);

    always_comb begin
        o_mem         = '0;
        o_mem.rd_addr = node_addr(r_cur);
        o_mem.val_wa  = node_addr(r_node);
        o_mem.val_wd  = r_val;
        o_mem.lc_wa   = node_addr(r_node);
        o_mem.rc_wa   = node_addr(r_node);
        o_mem.pl_wa   = node_addr(r_node);
        case (r_state)
            S_AINIT: begin
                o_mem.val_we = 1'b1;
                o_mem.lc_we  = 1'b1;
                o_mem.rc_we  = 1'b1;
                o_mem.pl_we  = 1'b1;
            end
            S_ACMP: begin
                if (cmp_lt) begin
                    if (i_rd.pl == '0) begin
                        o_mem.pl_we = 1'b1;
                        o_mem.pl_wa = node_addr(r_cur);
                        o_mem.pl_wd = r_node;
                        o_mem.lc_we = 1'b1;
                        o_mem.lc_wd = r_cur;
                    end
                end else begin
                    o_mem.pl_we = 1'b1;
                    o_mem.pl_wd = r_cur;
                    o_mem.lc_we = 1'b1;
                    o_mem.lc_wd = i_rd.rc;
                    o_mem.rc_we = 1'b1;
                    o_mem.rc_wa = node_addr(r_cur);
                    o_mem.rc_wd = r_node;
                end
            end
            S_AFIX: begin
                o_mem.pl_we = 1'b1;
                o_mem.pl_wa = node_addr(r_moved);
                o_mem.pl_wd = r_node;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_root      <= '0;
            r_last      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_val <= i_req.value;
                        r_lo  <= req_lo;
                        r_hi  <= req_hi;
                        if (i_req.kind == KIND_APPEND) begin
                            if (r_count == MAX_NODE) begin
                                r_res.max_value <= '0;
                                r_res.error     <= 1'b1;
                                r_state         <= S_EMIT;
                            end else begin
                                r_node  <= r_count + NODE_W'(1);
                                r_state <= S_AINIT;
                            end
                        end else if (req_bad) begin
                            r_res.max_value <= '0;
                            r_res.error     <= 1'b1;
                            r_state         <= S_EMIT;
                        end else begin
                            r_cur   <= r_root;
                            r_state <= S_QWAIT;
                        end
                    end
                end
                S_AINIT: begin
                    r_count <= r_node;
                    if (r_node == NODE_W'(1)) begin
                        r_root  <= r_node;
                        r_last  <= r_node;
                        r_state <= S_IDLE;
                    end else begin
                        r_cur   <= r_last;
                        r_state <= S_AWAIT;
                    end
                end
                S_AWAIT: begin
                    r_state <= S_ACMP;
                end
                S_ACMP: begin
                    if (cmp_lt) begin
                        if (i_rd.pl == '0) begin
                            r_root  <= r_node;
                            r_last  <= r_node;
                            r_state <= S_IDLE;
                        end else begin
                            r_cur   <= i_rd.pl;
                            r_state <= S_AWAIT;
                        end
                    end else begin
                        r_moved <= i_rd.rc;
                        if (i_rd.rc == '0) begin
                            r_last  <= r_node;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_AFIX;
                        end
                    end
                end
                S_AFIX: begin
                    r_last  <= r_node;
                    r_state <= S_IDLE;
                end
                S_QWAIT: begin
                    r_state <= S_QCMP;
                end
                S_QCMP: begin
                    if (cur_in) begin
                        r_res.max_value <= i_rd.value;
                        r_res.error     <= 1'b0;
                        r_state         <= S_EMIT;
                    end else if (desc_next == '0) begin
                        r_res.max_value <= '0;
                        r_res.error     <= 1'b1;
                        r_state         <= S_EMIT;
                    end else begin
                        r_cur   <= desc_next;
                        r_state <= S_QWAIT;
                    end
                end
                S_EMIT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_last == r_count))
        else $error("last node out of step with entry count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_root == '0))
        else $error("root presence disagrees with entry count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACMP) |-> ((r_cur != '0) && (r_cur < r_node)))
        else $error("climb reached an invalid node");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QWAIT) |-> ((r_cur != '0) && (r_cur <= r_count)))
        else $error("descent reached an invalid node");

endmodule

/* hdl/cartesian_tree_range_max.sv */
// cartesian_tree_range_max: top level, node stores and the sequencer.
// Append: an init step, then a read-wait and a compare step per node compared on the climb,
// plus a fix-up step when a subtree moves. Query: a read-wait and a compare step per node.
// Errors (full store, bad position): go straight from idle to the emit step.
// One request at a time; the node-store read port sets the per-level cost.
// Reset: synchronous, clears root, last node and count; stores are not swept.
`timescale 1ns / 1ps

module cartesian_tree_range_max
    import ctrm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_mem_cmd mem_cmd;
    t_mem_rd  mem_rd;

    ctrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .o_mem       (mem_cmd),
        .i_rd        (mem_rd)
    );

    ctrm_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ENTRIES)) u_value_store (
        .i_clk (i_clk),
        .i_we  (mem_cmd.val_we),
        .i_wa  (mem_cmd.val_wa),
        .i_wd  (mem_cmd.val_wd),
        .i_ra  (mem_cmd.rd_addr),
        .o_rd  (mem_rd.value)
    );

    ctrm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ENTRIES)) u_left_child (
        .i_clk (i_clk),
        .i_we  (mem_cmd.lc_we),
        .i_wa  (mem_cmd.lc_wa),
        .i_wd  (mem_cmd.lc_wd),
        .i_ra  (mem_cmd.rd_addr),
        .o_rd  (mem_rd.lc)
    );

    ctrm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ENTRIES)) u_right_child (
        .i_clk (i_clk),
        .i_we  (mem_cmd.rc_we),
        .i_wa  (mem_cmd.rc_wa),
        .i_wd  (mem_cmd.rc_wd),
        .i_ra  (mem_cmd.rd_addr),
        .o_rd  (mem_rd.rc)
    );

    ctrm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ENTRIES)) u_parent_link (
        .i_clk (i_clk),
        .i_we  (mem_cmd.pl_we),
        .i_wa  (mem_cmd.pl_wa),
        .i_wd  (mem_cmd.pl_wd),
        .i_ra  (mem_cmd.rd_addr),
        .o_rd  (mem_rd.pl)
    );

endmodule

/* tb/testbench.sv */
// testbench: drives the Cartesian-tree range-maximum engine through directed and random
// append/query requests and checks every result against an in-bench tree predictor.
// Depends on ctrm_pkg and cartesian_tree_range_max.
`timescale 1ns / 1ps

module testbench;
    import ctrm_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 2 * MAX_ENTRIES + 16;
    localparam int CYCLE_LIMIT  = 15_000_000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp;

    bit no_idle  = 1'b0;
    bit hold_rsp = 1'b0;
    int mismatches  = 0;
    int cycle_count = 0;

    // tree predictor state; node 0 means no node
    logic [VALUE_W-1:0] node_val   [0:MAX_ENTRIES];
    int unsigned        node_left  [0:MAX_ENTRIES];
    int unsigned        node_right [0:MAX_ENTRIES];
    int unsigned        node_up    [0:MAX_ENTRIES];
    int unsigned        tree_root  = 0;
    int unsigned        tree_tail  = 0;
    int unsigned        node_count = 0;

    t_rsp pending_max_q[$];
    t_rsp want_rsp;

    cartesian_tree_range_max dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic void predict_range_max(input t_req item);
        int unsigned n, cur, moved, lo, hi, steps;
        t_rsp res;
        res.max_value = '0;
        res.error     = 1'b1;
        if (item.kind == KIND_APPEND) begin
            if (node_count >= MAX_ENTRIES) begin
                pending_max_q.push_back(res);
                return;
            end
            n = node_count + 1;
            node_val[n]   = item.value;
            node_left[n]  = 0;
            node_right[n] = 0;
            node_up[n]    = 0;
            node_count    = n;
            if (n == 1) begin
                tree_root = 1;
                tree_tail = 1;
                return;
            end
            cur = tree_tail;
            while (cur != 0 && node_val[cur] < item.value) begin
                if (node_up[cur] == 0) begin
                    node_up[cur] = n;
                    node_left[n] = cur;
                    tree_root    = n;
                    cur          = 0;
                end else begin
                    cur = node_up[cur];
                end
            end
            if (cur != 0) begin
                moved           = node_right[cur];
                node_up[n]      = cur;
                node_left[n]    = moved;
                node_right[cur] = n;
                if (moved != 0)
                    node_up[moved] = n;
            end
            tree_tail = n;
            return;
        end
        lo = item.left_position;
        hi = item.right_position;
        if (lo > hi) begin
            lo = item.right_position;
            hi = item.left_position;
        end
        if (lo != 0 && hi <= node_count) begin
            cur = tree_root;
            for (steps = 0; steps <= MAX_ENTRIES && cur != 0; steps++) begin
                if (cur >= lo && cur <= hi) begin
                    res.max_value = node_val[cur];
                    res.error     = 1'b0;
                    break;
                end
                cur = (cur < lo) ? node_right[cur] : node_left[cur];
            end
        end
        pending_max_q.push_back(res);
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_req make_append(input logic [VALUE_W-1:0] v);
        t_req item;
        item.kind           = KIND_APPEND;
        item.value          = v;
        item.left_position  = POS_W'($urandom);
        item.right_position = POS_W'($urandom);
        return item;
    endfunction

    function automatic t_req make_query(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
        t_req item;
        item.kind           = KIND_QUERY;
        item.value          = VALUE_W'($urandom);
        item.left_position  = a;
        item.right_position = b;
        return item;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        if ($urandom_range(0, 3) == 0)
            return VALUE_W'($urandom_range(0, 15));
        return VALUE_W'($urandom);
    endfunction

    function automatic t_req rand_query();
        int r, lo, hi;
        r = $urandom_range(0, 99);
        if (node_count == 0 || r < 8)
            return make_query(POS_W'($urandom), POS_W'($urandom));
        if (r < 12)
            return make_query('0, POS_W'($urandom_range(1, node_count)));
        if (r < 16)
            return make_query(POS_W'(node_count + 1), POS_W'($urandom_range(1, node_count)));
        lo = $urandom_range(1, node_count);
        if (r < 55) begin
            hi = lo + $urandom_range(0, 3);
            if (hi > node_count)
                hi = node_count;
        end else begin
            hi = $urandom_range(1, node_count);
        end
        if ($urandom_range(0, 1))
            return make_query(POS_W'(lo), POS_W'(hi));
        return make_query(POS_W'(hi), POS_W'(lo));
    endfunction

    task automatic send_req(input t_req item);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
        predict_range_max(item);
    endtask

    // response side: random stalls, plus one long hold when requested
    initial begin
        int stall;
        forever begin
            @(negedge clk);
            if (hold_rsp) begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_rsp = 1'b0;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    rsp_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) begin
            if (pending_max_q.size() == 0) begin
                $display("%0t MISMATCH unexpected result: max_value %h error %b",
                         $time, rsp.max_value, rsp.error);
                mismatches++;
            end else begin
                want_rsp = pending_max_q.pop_front();
                if (rsp.max_value !== want_rsp.max_value) begin
                    $display("%0t MISMATCH max_value: expected %h actual %h",
                             $time, want_rsp.max_value, rsp.max_value);
                    mismatches++;
                end
                if (rsp.error !== want_rsp.error) begin
                    $display("%0t MISMATCH error: expected %b actual %b",
                             $time, want_rsp.error, rsp.error);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_directed_edges();
        send_req(make_query(11'd1, 11'd1));       // empty store
        send_req(make_append(30'd5));
        send_req(make_query(11'd0, 11'd1));
        send_req(make_query(11'd1, 11'd2));
        send_req(make_query(11'd1, 11'd1));
        send_req(make_append(30'd3));
        send_req(make_append(30'd4));             // takes over a right subtree
        send_req(make_query(11'd2, 11'd2));
        send_req(make_query(11'd3, 11'd1));
        send_req(make_query(11'd2, 11'd3));
        send_req(make_append(30'd6));             // climbs past the root
        send_req(make_append(30'd6));             // tie keeps earlier node above
        send_req(make_query(11'd4, 11'd5));
        send_req(make_append(VALUE_MAX));
        send_req(make_append(30'd0));
        send_req(make_query(11'd7, 11'd6));
        send_req(make_query(11'd8, 11'd8));
        send_req(make_query(11'd1, 11'd8));
        send_req(make_query(11'd2047, 11'd1));
        send_req(make_query(11'd1024, 11'd1));
    endtask

    task automatic test_random_mix();
        int sent, seg, len, k;
        longint v;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 9) == 0);
            seg = $urandom_range(0, 9);
            len = $urandom_range(2, 16);
            v   = rand_value();
            for (k = 0; k < len; k++) begin
                case (seg)
                    4: begin
                        send_req(make_append(VALUE_W'(v)));
                        v = v - $urandom_range(0, 1000);
                        if (v < 0)
                            v = 0;
                    end
                    5: begin
                        send_req(make_append(VALUE_W'(v)));
                        v = v + $urandom_range(0, 1000);
                        if (v > VALUE_MAX)
                            v = VALUE_MAX;
                    end
                    6: send_req(make_append(VALUE_W'(v)));
                    7, 8, 9: send_req(rand_query());
                    default: begin
                        if ($urandom_range(0, 99) < 55)
                            send_req(make_append(rand_value()));
                        else
                            send_req(rand_query());
                    end
                endcase
            end
            sent += len;
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_rsp = 1'b1;
        repeat (12) send_req(rand_query());
    endtask

    task automatic test_fill_store();
        while (node_count < MAX_ENTRIES) begin
            if ($urandom_range(0, 7) == 0)
                send_req(rand_query());
            else
                send_req(make_append(rand_value()));
        end
    endtask

    task automatic test_full_store();
        send_req(make_append(VALUE_MAX));
        send_req(make_append(30'd0));
        send_req(make_append(rand_value()));
        send_req(make_query(11'd1, 11'd1024));
        send_req(make_query(11'd1024, 11'd1024));
        send_req(make_query(11'd1025, 11'd1));
        send_req(make_query(11'd0, 11'd1024));
        send_req(make_query(11'd2047, 11'd2047));
        repeat (40) send_req(rand_query());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_edges();
        test_random_mix();
        test_backpressure();
        test_fill_store();
        test_full_store();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_max_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
